// ----- hdl/rswc_pkg.sv -----
package rswc_pkg;

  localparam int unsigned CfgW    = 21;
  localparam int unsigned PosW    = 20;
  localparam int unsigned CountW  = 19;
  localparam int unsigned IndexW  = 16;
  localparam int unsigned NCells  = 4;
  localparam int unsigned NLong   = 4;
  localparam int unsigned HitW    = 3;

  localparam logic [CfgW-1:0]   LenMax    = 21'h100000;
  localparam logic [CfgW-1:0]   LenReset  = 21'd25000;
  localparam logic [CountW-1:0] CountMax  = 19'h7FFFF;
  localparam logic [IndexW-1:0] IndexMax  = 16'hFFFF;

  typedef logic [1:0] base_t;

  // four-base site, two bits a base, oldest base high
  localparam logic [7:0] SiteShort = 8'h8D;

  // five-base sites
  localparam logic [9:0] SiteLong [NLong] = '{10'h20D, 10'h21D, 10'h22D, 10'h23D};

  typedef struct packed {
    logic advance;
    logic close;
  } cell_ctrl_t;

  typedef struct packed {
    logic [CountW-1:0] cut_count;
    logic [IndexW-1:0] window_index;
    logic              last_window;
  } result_t;

endpackage

// ----- hdl/rswc_cell.sv -----
module rswc_cell
  import rswc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  base_t      base_i,
  input  logic       in_win_i,
  output base_t      base_o,
  output logic       in_win_o
);

  base_t base_q;
  logic  in_win_q, in_win_d;

  assign in_win_d = ctrl_i.close ? 1'b0 : in_win_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_win_q <= 1'b0;
    end else if (ctrl_i.advance) begin
      in_win_q <= in_win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      base_q <= base_i;
    end
  end

  assign base_o   = base_q;
  assign in_win_o = in_win_q;

endmodule

// ----- hdl/rswc_match.sv -----
module rswc_match
  import rswc_pkg::*;
(
  input  base_t            base_i,
  input  base_t            hist_i [NCells],
  input  logic [NCells-1:0] in_win_i,
  output logic [HitW-1:0]  hit_o
);

  logic [9:0] word;
  logic       short_hit;
  logic [NLong-1:0] long_hit;

  // hist_i[0] is the newest stored base
  assign word = {hist_i[3], hist_i[2], hist_i[1], hist_i[0], base_i};

  assign short_hit = (word[7:0] == SiteShort) && (&in_win_i[2:0]);

  always_comb begin
    for (int k = 0; k < NLong; k++) begin
      long_hit[k] = (word == SiteLong[k]) && (&in_win_i);
    end
  end

  assign hit_o = HitW'(short_hit) + HitW'(long_hit[0]) + HitW'(long_hit[1])
               + HitW'(long_hit[2]) + HitW'(long_hit[3]);

endmodule

// ----- hdl/rswc_window.sv -----
module rswc_window
  import rswc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic            last_i,
  input  logic [HitW-1:0] hit_i,
  input  logic [CfgW-1:0] len_i,
  output logic            close_o,
  output logic            emit_o,
  output result_t         result_o
);

  logic [PosW-1:0]   pos_q, pos_d;
  logic [CountW-1:0] count_q, count_d, count_sum;
  logic [IndexW-1:0] index_q, index_d;
  logic [CfgW-1:0]   pos_new;
  logic [CountW:0]   sum_wide;
  logic              full;

  assign pos_new   = {1'b0, pos_q} + CfgW'(1);
  assign full      = pos_new >= len_i;
  assign sum_wide  = {1'b0, count_q} + (CountW + 1)'(hit_i);
  assign count_sum = (sum_wide > {1'b0, CountMax}) ? CountMax : sum_wide[CountW-1:0];

  assign close_o = full || last_i;
  assign emit_o  = close_o && (full || (index_q != '0));

  assign result_o.cut_count    = count_sum;
  assign result_o.window_index = index_q;
  assign result_o.last_window  = last_i;

  always_comb begin
    pos_d   = pos_new[PosW-1:0];
    count_d = count_sum;
    index_d = index_q;
    if (close_o) begin
      pos_d   = '0;
      count_d = '0;
      if (last_i) begin
        index_d = '0;
      end else if (index_q != IndexMax) begin
        index_d = index_q + IndexW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      count_q <= '0;
      index_q <= '0;
    end else if (fire_i) begin
      pos_q   <= pos_d;
      count_q <= count_d;
      index_q <= index_d;
    end
  end

  ap_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && last_i |=> (index_q == '0) && (pos_q == '0) && (count_q == '0))
    else $error("state not cleared after final base");

  ap_close_resets_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && close_o |=> (pos_q == '0) && (count_q == '0))
    else $error("window not restarted after close");

  ap_index_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !close_o |=> index_q == $past(index_q))
    else $error("window index moved inside a window");

endmodule

// ----- hdl/restriction_site_window_counter_core.sv -----
// Counts GATC, GAATC, GACTC, GAGTC and GATTC sites in consecutive windows of a
// DNA stream taken one 2-bit base per beat. The block accepts one base every
// clock cycle; a window result appears in the output register in the cycle
// after the base that closes the window and is held until taken; a first window
// cut short by the last base gives no result. The input stalls only while that
// register holds a result that is not taken in the same cycle. The previous
// four bases sit in a chain of four cells that shift on every accepted base and
// carry an in-window flag each. A written window length of zero acts as one,
// above 1048576 as 1048576, and applies from the next base.
module restriction_site_window_counter_core
  import rswc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CfgW-1:0]   cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        base_i,
  input  logic              last_base_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CountW-1:0] cut_count_o,
  output logic [IndexW-1:0] window_index_o,
  output logic              last_window_o
);

  logic [CfgW-1:0]   len_q;
  logic              in_fire;
  cell_ctrl_t        ctrl;
  base_t             hist [NCells];
  logic [NCells-1:0] in_win;
  logic [HitW-1:0]   hit;
  logic              close, emit;
  result_t           result, out_q;
  logic              out_valid_q, out_valid_d;

  assign cfg_ready_o = 1'b1;

  // effective length kept in the register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenReset;
    end else if (cfg_valid_i) begin
      if (cfg_data_i == '0) begin
        len_q <= CfgW'(1);
      end else if (cfg_data_i > LenMax) begin
        len_q <= LenMax;
      end else begin
        len_q <= cfg_data_i;
      end
    end
  end

  assign in_ready_o   = !out_valid_q || out_ready_i;
  assign in_fire      = in_valid_i && in_ready_o;
  assign ctrl.advance = in_fire;
  assign ctrl.close   = close;

  for (genvar i = 0; i < NCells; i++) begin : g_cell
    if (i == 0) begin : g_head
      rswc_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (ctrl),
        .base_i   (base_i),
        .in_win_i (1'b1),
        .base_o   (hist[i]),
        .in_win_o (in_win[i])
      );
    end else begin : g_body
      rswc_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (ctrl),
        .base_i   (hist[i-1]),
        .in_win_i (in_win[i-1]),
        .base_o   (hist[i]),
        .in_win_o (in_win[i])
      );
    end
  end

  rswc_match u_match (
    .base_i   (base_i),
    .hist_i   (hist),
    .in_win_i (in_win),
    .hit_o    (hit)
  );

  rswc_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (in_fire),
    .last_i   (last_base_i),
    .hit_i    (hit),
    .len_i    (len_q),
    .close_o  (close),
    .emit_o   (emit),
    .result_o (result)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cut_count_o    = out_q.cut_count;
  assign window_index_o = out_q.window_index;
  assign last_window_o  = out_q.last_window;

  ap_flag_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_win[1] || in_win[0]) && (!in_win[2] || in_win[1]) && (!in_win[3] || in_win[2]))
    else $error("in-window flags not contiguous");

  ap_emit_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && emit |=> out_valid_o && (last_window_o == $past(last_base_i)))
    else $error("window result not registered");

  ap_close_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && close |=> in_win == '0)
    else $error("cells still in window after close");

endmodule

// ----- sim/restriction_site_window_counter_core_test.sv -----
`timescale 1ns / 1ps

module restriction_site_window_counter_core_test;
  import rswc_pkg::*;

  localparam base_t BaseA = 2'd0;
  localparam base_t BaseC = 2'd1;
  localparam base_t BaseG = 2'd2;
  localparam base_t BaseT = 2'd3;

  localparam int unsigned RandomBases = 600;
  localparam logic [CfgW-1:0] LenAllOnes = 21'h1FFFFF;

  typedef enum logic [1:0] {ROW_LEN, ROW_BASE, ROW_DRAIN} row_kind_e;
  typedef enum logic [1:0] {SINK_OPEN, SINK_LIGHT, SINK_BUSY} sink_mode_e;

  typedef struct packed {
    row_kind_e       kind;
    logic [CfgW-1:0] len;
    base_t           b;
    logic            last;
    logic            pin;
    logic            has;
    result_t         res;
  } row_t;

  localparam int unsigned NRows = 30;
  localparam row_t Rows [NRows] = '{
    '{ROW_LEN,  21'd0,      BaseA, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_BASE, 21'd0,      BaseA, 1'b0, 1'b1, 1'b1, '{19'd0, 16'd0, 1'b0}},
    '{ROW_BASE, 21'd0,      BaseG, 1'b1, 1'b1, 1'b1, '{19'd0, 16'd1, 1'b1}},
    '{ROW_LEN,  21'd4,      BaseA, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_BASE, 21'd0,      BaseG, 1'b0, 1'b1, 1'b0, '0},
    '{ROW_BASE, 21'd0,      BaseA, 1'b0, 1'b1, 1'b0, '0},
    '{ROW_BASE, 21'd0,      BaseT, 1'b0, 1'b1, 1'b0, '0},
    '{ROW_BASE, 21'd0,      BaseC, 1'b1, 1'b1, 1'b1, '{19'd1, 16'd0, 1'b1}},
    '{ROW_LEN,  21'd5,      BaseA, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_BASE, 21'd0,      BaseG, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_BASE, 21'd0,      BaseA, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_BASE, 21'd0,      BaseA, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_BASE, 21'd0,      BaseT, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_BASE, 21'd0,      BaseC, 1'b0, 1'b1, 1'b1, '{19'd1, 16'd0, 1'b0}},
    '{ROW_BASE, 21'd0,      BaseG, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_BASE, 21'd0,      BaseA, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_DRAIN, 21'd0,     BaseA, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_BASE, 21'd0,      BaseC, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_BASE, 21'd0,      BaseT, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_BASE, 21'd0,      BaseC, 1'b1, 1'b1, 1'b1, '{19'd1, 16'd1, 1'b1}},
    '{ROW_BASE, 21'd0,      BaseT, 1'b0, 1'b1, 1'b0, '0},
    '{ROW_BASE, 21'd0,      BaseT, 1'b1, 1'b1, 1'b0, '0},
    '{ROW_LEN,  LenAllOnes, BaseA, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_BASE, 21'd0,      BaseG, 1'b0, 1'b1, 1'b0, '0},
    '{ROW_BASE, 21'd0,      BaseA, 1'b0, 1'b1, 1'b0, '0},
    '{ROW_BASE, 21'd0,      BaseG, 1'b0, 1'b1, 1'b0, '0},
    '{ROW_BASE, 21'd0,      BaseT, 1'b0, 1'b1, 1'b0, '0},
    '{ROW_BASE, 21'd0,      BaseC, 1'b1, 1'b1, 1'b0, '0},
    '{ROW_LEN,  LenMax,     BaseA, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_BASE, 21'd0,      BaseT, 1'b1, 1'b1, 1'b0, '0}
  };

  localparam int unsigned NPhaseLens = 14;
  localparam logic [CfgW-1:0] PhaseLens [NPhaseLens] = '{
    21'd5, 21'd5, 21'd4, 21'd6, 21'd7, 21'd3, 21'd2, 21'd1, 21'd9, 21'd16, 21'd40,
    21'd0, LenMax, LenAllOnes
  };

  logic              clk         = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CfgW-1:0]   cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  base_t             base_i      = BaseA;
  logic              last_base_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CountW-1:0] cut_count_o;
  logic [IndexW-1:0] window_index_o;
  logic              last_window_o;

  // typed expectation travelling with the beat
  logic    pin_q     = 1'b0;
  logic    pin_has_q = 1'b0;
  result_t pin_res_q = '0;

  logic [CfgW-1:0]   win_len;
  logic [7:0]        seq_hist;
  logic [2:0]        win_seen;
  logic [PosW-1:0]   win_pos;
  logic [CountW-1:0] win_cut_count;
  logic [IndexW-1:0] win_index;

  result_t     window_results_q [$];
  int unsigned mismatches = 0;
  int unsigned random_bases = 0;
  bit          burst = 1'b0;
  sink_mode_e  sink_mode = SINK_BUSY;
  bit          sink_on = 1'b0;
  int unsigned sink_left = 0;

  restriction_site_window_counter_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .base_i         (base_i),
    .last_base_i    (last_base_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cut_count_o    (cut_count_o),
    .window_index_o (window_index_o),
    .last_window_o  (last_window_o)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // advances the window state by one base, returns 1 when a window closes with a result
  function automatic bit tally_base(input base_t b, input logic last, output result_t r);
    logic [9:0]      word;
    logic [2:0]      have;
    logic [2:0]      hits;
    logic [CountW:0] sum;
    logic [CfgW-1:0] eff;
    logic [CfgW-1:0] nxt;
    bit              emit;
    word = {seq_hist, b};
    have = (win_seen >= 3'd5) ? 3'd5 : win_seen + 3'd1;
    hits = '0;
    r    = '0;
    if (have >= 3'd4 && word[7:0] == SiteShort) hits++;
    for (int k = 0; k < NLong; k++) begin
      if (have == 3'd5 && word == SiteLong[k]) hits++;
    end
    sum = win_cut_count + hits;
    win_cut_count = (sum > CountMax) ? CountMax : sum[CountW-1:0];
    seq_hist = word[7:0];
    win_seen = have;
    if (win_len == '0) eff = 21'd1;
    else if (win_len > LenMax) eff = LenMax;
    else eff = win_len;
    nxt = {1'b0, win_pos} + 21'd1;
    if (nxt < eff && !last) begin
      win_pos = nxt[PosW-1:0];
      return 1'b0;
    end
    emit = (nxt >= eff) || (win_index != '0);
    r.cut_count    = win_cut_count;
    r.window_index = win_index;
    r.last_window  = last;
    win_cut_count = '0;
    win_pos       = '0;
    win_seen      = '0;
    if (last) begin
      win_index = '0;
      seq_hist  = '0;
    end else if (win_index != IndexMax) begin
      win_index++;
    end
    return emit;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t pred;
    bit      produced;
    if (!rst_ni) begin
      win_len       = LenReset;
      seq_hist      = '0;
      win_seen      = '0;
      win_pos       = '0;
      win_cut_count = '0;
      win_index     = '0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (window_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected window result: cut_count %0d window_index %0d last_window %0b",
                     cut_count_o, window_index_o, last_window_o);
        end else begin
          want = window_results_q[0];
          window_results_q.delete(0);
          if (cut_count_o !== want.cut_count || window_index_o !== want.window_index ||
              last_window_o !== want.last_window) begin
            mismatches++;
            if (mismatches <= 10)
              $display("window mismatch (exp/got): cut_count %0d/%0d window_index %0d/%0d",
                       want.cut_count, cut_count_o, want.window_index, window_index_o,
                       " last_window %0b/%0b", want.last_window, last_window_o);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) win_len = cfg_data_i;
      if (in_valid_i && in_ready_o) begin
        produced = tally_base(base_i, last_base_i, pred);
        if (pin_q) begin
          if (pin_has_q) window_results_q.push_back(pin_res_q);
        end else if (produced) begin
          window_results_q.push_back(pred);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (sink_left != 0) begin
      sink_left--;
    end else if (sink_mode == SINK_OPEN) begin
      sink_on = 1'b1;
    end else if (!sink_on) begin
      sink_on   = 1'b1;
      sink_left = (sink_mode == SINK_LIGHT) ? $urandom_range(4, 40) : $urandom_range(0, 12);
    end else begin
      sink_on   = 1'b0;
      sink_left = (sink_mode == SINK_LIGHT) ? 0 : pick_gap();
    end
    out_ready_i <= sink_on;
  end

  task automatic send_base(input base_t b, input logic last, input logic pin, input logic has,
                           input result_t r);
    int unsigned gap;
    in_valid_i  <= 1'b1;
    base_i      <= b;
    last_base_i <= last;
    pin_q       <= pin;
    pin_has_q   <= has;
    pin_res_q   <= r;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    gap = burst ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk);
    while (window_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_len(input logic [CfgW-1:0] v);
    drain();
    repeat (4) @(posedge clk);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  // random bases with whole or cut-off sites mixed in
  task automatic send_sequence(input int unsigned n, input bit terminate);
    base_t       pend [$];
    logic [9:0]  code;
    int unsigned k;
    base_t       b;
    for (int unsigned i = 0; i < n; i++) begin
      if (pend.size() == 0 && $urandom_range(0, 99) < 40) begin
        k = $urandom_range(0, NLong);
        if (k == 0) begin
          for (int j = 0; j < 4; j++) pend.push_back(SiteShort[7 - 2 * j -: 2]);
        end else begin
          code = SiteLong[k - 1];
          for (int j = 0; j < 5; j++) pend.push_back(code[9 - 2 * j -: 2]);
        end
      end
      if (pend.size() != 0) begin
        b = pend[0];
        pend.delete(0);
      end else begin
        b = base_t'($urandom_range(0, 3));
      end
      send_base(b, terminate && (i == n - 1), 1'b0, 1'b0, '0);
      random_bases++;
      if ($urandom_range(0, 79) == 0) drain();
    end
  endtask

  initial begin
    logic [CfgW-1:0] len;
    int unsigned     eff;
    int unsigned     seq_max;
    int unsigned     nseq;
    int unsigned     phase;
    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NRows; i++) begin
      case (Rows[i].kind)
        ROW_LEN:   write_len(Rows[i].len);
        ROW_DRAIN: drain();
        default:   send_base(Rows[i].b, Rows[i].last, Rows[i].pin, Rows[i].has, Rows[i].res);
      endcase
    end

    phase = 0;
    while (random_bases < RandomBases) begin
      len = (phase < NPhaseLens) ? PhaseLens[phase] : CfgW'($urandom_range(1, 48));
      write_len(len);
      burst     = ($urandom_range(0, 3) == 0);
      sink_mode = sink_mode_e'($urandom_range(0, 2));
      eff = (len == '0) ? 1 : len;
      if (eff > 64) seq_max = 24;
      else seq_max = (3 * eff + 4 > 60) ? 60 : 3 * eff + 4;
      nseq = $urandom_range(2, 4);
      // a phase may stop mid-window so the new length meets a partly filled window
      for (int unsigned s = 0; s < nseq; s++)
        send_sequence($urandom_range(1, seq_max), (s != nseq - 1) || $urandom_range(0, 1));
      phase++;
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && window_results_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
